// ----- rtl/core/nlp_pkg.sv -----
// ---------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the next lexicographic permutation pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package nlp_pkg;

  localparam int unsigned Slots    = 8;
  localparam int unsigned ElemW    = 4;
  localparam int unsigned LenW     = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned WordW    = Slots * ElemW;

  typedef logic [Slots-1:0][ElemW-1:0] elems_t;

  typedef struct packed {
    logic             valid;
    elems_t           elems;
    logic [LenW-1:0]  len;
    logic             found;
    logic [IdxW-1:0]  pivot;
  } stage_t;

endpackage

`default_nettype wire

// ----- rtl/core/nlp_pivot.sv -----
// ---------------------------------------------------------------------------
// nlp_pivot
// First stage: unpacks and masks the sequence, finds the last ascent.
// ---------------------------------------------------------------------------
`default_nettype none

module nlp_pivot
  import nlp_pkg::*;
#(
  parameter int unsigned EffMax = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [WordW-1:0]    perm_in_i,
  input  logic [LenW-1:0]     seq_length_i,
  output stage_t              stage_o
);

  stage_t               stage_d, stage_q;
  logic [LenW-1:0]      len;
  logic [Slots-2:0]     asc;

  always_comb begin
    len = (seq_length_i > LenW'(EffMax)) ? LenW'(EffMax) : seq_length_i;
    stage_d       = '0;
    stage_d.valid = accept_i;
    stage_d.len   = len;
    for (int k = 0; k < Slots; k++) begin
      stage_d.elems[k] = (LenW'(k) < len) ? perm_in_i[k*ElemW +: ElemW] : '0;
    end
    for (int k = 0; k < Slots - 1; k++) begin
      asc[k] = (LenW'(k + 1) < len) && (stage_d.elems[k] < stage_d.elems[k+1]);
    end
    stage_d.found = |asc;
    stage_d.pivot = '0;
    for (int k = 0; k < Slots - 1; k++) begin
      if (asc[k]) begin
        stage_d.pivot = IdxW'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- rtl/core/nlp_swap.sv -----
// ---------------------------------------------------------------------------
// nlp_swap
// Second stage: swaps the pivot with the rightmost larger element after it.
// ---------------------------------------------------------------------------
`default_nettype none

module nlp_swap
  import nlp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  stage_t  stage_i,
  output stage_t  stage_o
);

  stage_t             stage_d, stage_q;
  logic [ElemW-1:0]   piv_val;
  logic [Slots-1:0]   larger;
  logic [IdxW-1:0]    swap_idx;

  always_comb begin
    stage_d  = stage_i;
    piv_val  = stage_i.elems[stage_i.pivot];
    swap_idx = stage_i.pivot;
    for (int k = 0; k < Slots; k++) begin
      larger[k] = (IdxW'(k) > stage_i.pivot) && (LenW'(k) < stage_i.len)
                  && (stage_i.elems[k] > piv_val);
      if (larger[k]) begin
        swap_idx = IdxW'(k);
      end
    end
    if (stage_i.found) begin
      stage_d.elems[stage_i.pivot] = stage_i.elems[swap_idx];
      stage_d.elems[swap_idx]      = piv_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- rtl/core/nlp_reverse.sv -----
// ---------------------------------------------------------------------------
// nlp_reverse
// Third stage: reverses the non-increasing tail after the pivot when one was
// found, and packs the result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module nlp_reverse
  import nlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stage_t            stage_i,
  output logic              done_o,
  output logic [WordW-1:0]  perm_out_o,
  output logic              exhausted_o
);

  logic               done_d, done_q;
  logic [WordW-1:0]   perm_d, perm_q;
  logic               exh_d, exh_q;
  logic [LenW-1:0]    src;

  always_comb begin
    done_d = stage_i.valid;
    exh_d  = !stage_i.found;
    perm_d = '0;
    src    = '0;
    for (int k = 0; k < Slots; k++) begin
      src = stage_i.len + LenW'(stage_i.pivot) - LenW'(k);
      if (stage_i.found && (IdxW'(k) > stage_i.pivot) && (LenW'(k) < stage_i.len)) begin
        perm_d[k*ElemW +: ElemW] = stage_i.elems[src[IdxW-1:0]];
      end else begin
        perm_d[k*ElemW +: ElemW] = stage_i.elems[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    perm_q <= perm_d;
    exh_q  <= exh_d;
  end

  assign done_o      = done_q;
  assign perm_out_o  = perm_q;
  assign exhausted_o = exh_q;

endmodule

`default_nettype wire

// ----- rtl/core/next_lexicographic_permutation.sv -----
// ---------------------------------------------------------------------------
// next_lexicographic_permutation
// Returns the next sequence in ascending lexicographic order of a packed
// sequence of up to eight 4-bit elements.
// ---------------------------------------------------------------------------
// usage:
//   command channel: drive perm_in_i and seq_length_i with start high; the
//   beat is taken at a rising edge where start is high and busy is low.
//   busy stays low, so a new beat may be issued in every cycle.
//   result channel: done_o is high for one cycle with perm_out_o and
//   exhausted_o, once the beat has passed the pivot, swap and reversal registers.
//   throughput: one beat per cycle, set by the three register stages
//   (pivot search, swap, tail reversal).
//   the length is clamped to MAX_LEN and to eight slots; positions at or
//   beyond it read as zero. exhausted_o flags a sequence with no successor,
//   which then comes back unchanged.
//   reset clears the stage valid bits; beats in flight are dropped.
//   results cannot be held off by the receiver; they must be taken in the
//   cycle done_o is high.
// ---------------------------------------------------------------------------
`default_nettype none

module next_lexicographic_permutation
  import nlp_pkg::*;
#(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [WordW-1:0]  perm_in_i,
  input  logic [LenW-1:0]   seq_length_i,
  output logic              done_o,
  output logic [WordW-1:0]  perm_out_o,
  output logic              exhausted_o
);

  localparam int unsigned EffMax = (MAX_LEN < Slots) ? MAX_LEN : Slots;

  stage_t pivot_stage;
  stage_t swap_stage;

  assign busy = 1'b0;

  nlp_pivot #(
    .EffMax(EffMax)
  ) u_pivot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (start && !busy),
    .perm_in_i   (perm_in_i),
    .seq_length_i(seq_length_i),
    .stage_o     (pivot_stage)
  );

  nlp_swap u_swap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stage_i(pivot_stage),
    .stage_o(swap_stage)
  );

  nlp_reverse u_reverse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (swap_stage),
    .done_o     (done_o),
    .perm_out_o (perm_out_o),
    .exhausted_o(exhausted_o)
  );

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3))
    else $error("result beat without a command beat three cycles earlier");

  a_short_exhausted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(seq_length_i, 3) < LenW'(2))) |-> exhausted_o)
    else $error("short sequence not flagged exhausted");

  a_next_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !exhausted_o) |-> (perm_out_o != $past(perm_in_i, 3)))
    else $error("successor equals its input");
`endif

endmodule

`default_nettype wire
